[design/kqts_pkg.sv]
// Shared constants, types and codes for the k-mer query table search block.
`default_nettype none

package kqts_pkg;

  localparam int KMER_LEN    = 16;
  localparam int TABLE_DEPTH = 1024;
  localparam int POS_WIDTH   = 40;

  localparam int SYM_W   = 8;
  localparam int MODE_W  = 2;
  localparam int START_W = 40;
  localparam int RPT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int OFF_W  = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;
  localparam int FILL_W = $clog2(KMER_LEN + 1);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GENOME  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPORTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_KIND = 1'd1;

  localparam logic SEARCH_LINEAR = 1'b0;
  localparam logic SEARCH_BINARY = 1'b1;

  // byte 0 is the most significant byte, so an unsigned compare is lexicographic
  typedef logic [0:KMER_LEN-1][SYM_W-1:0] kmer_t;

endpackage

`default_nettype wire

[design/kmer_query_table_search.sv]
// K-mer query table with sliding genome window and linear or binary table search.
// Load, restart and clear words, and a genome word that leaves the window short,
// are taken in the idle state and give no result. A full window starts a search in which
// each probe is one table read and one 128-bit compare; a binary search halves the range
// per probe, a linear scan steps through the entries, and the result word is then offered.
// Synchronous active-low reset clears control and counters and restores config defaults.
`default_nettype none

module kmer_query_table_search (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [kqts_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [kqts_pkg::SYM_W-1:0]        in_symbol,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_found,
  output logic                                   out_reported,
  output logic [kqts_pkg::START_W-1:0]           out_start_index,
  input  wire logic                              cfg_we,
  input  wire logic [kqts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kqts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kqts_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_READ    = 2'd1;
  localparam logic [1:0] ST_COMPARE = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  kmer_t table_mem [TABLE_DEPTH];
  kmer_t rd_data_r;

  logic [1:0]           state_r, state_nxt;
  logic [RPT_W-1:0]     max_reports_r;
  logic                 search_kind_r;
  logic [CNT_W-1:0]     entry_count_r, entry_count_nxt;
  logic [OFF_W-1:0]     load_offset_r, load_offset_nxt;
  kmer_t                window_r, window_nxt;
  logic [FILL_W-1:0]    window_fill_r, window_fill_nxt;
  logic [POS_WIDTH-1:0] genome_pos_r, genome_pos_nxt;
  logic [RPT_W-1:0]     report_count_r, report_count_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [ADDR_W-1:0]    probe_r, probe_nxt;
  logic                 hit_r, hit_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r;
  logic                 out_reported_r;
  logic [START_W-1:0]   out_start_r;

  logic                 in_fire;
  logic                 out_load;
  logic                 table_wr;
  logic                 rep_c;
  logic [CNT_W-1:0]     span_c;
  logic [CNT_W-1:0]     mid_c;
  logic [ADDR_W-1:0]    rd_addr_c;
  logic                 cmp_eq_c;
  logic                 cmp_lt_c;
  logic [POS_WIDTH-1:0] start_pos_c;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign table_wr  = in_fire && (in_mode == MODE_LOAD) &&
                     (entry_count_r != CNT_W'(TABLE_DEPTH));
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign rep_c     = hit_r && (report_count_r < max_reports_r);

  assign span_c    = hi_r - lo_r - CNT_W'(1);
  assign mid_c     = lo_r + (span_c >> 1);
  assign rd_addr_c = (search_kind_r == SEARCH_BINARY) ? mid_c[ADDR_W-1:0] : lo_r[ADDR_W-1:0];
  assign cmp_eq_c  = (rd_data_r == window_r);
  assign cmp_lt_c  = (rd_data_r < window_r);
  assign start_pos_c = genome_pos_r - POS_WIDTH'(KMER_LEN);

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_reported    = out_reported_r;
  assign out_start_index = out_start_r;

  always_ff @(posedge clk) begin
    if (table_wr) begin
      table_mem[entry_count_r[ADDR_W-1:0]][load_offset_r] <= in_symbol;
    end
    rd_data_r <= table_mem[rd_addr_c];
  end

  always_comb begin
    state_nxt        = state_r;
    entry_count_nxt  = entry_count_r;
    load_offset_nxt  = load_offset_r;
    window_nxt       = window_r;
    window_fill_nxt  = window_fill_r;
    genome_pos_nxt   = genome_pos_r;
    report_count_nxt = report_count_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    probe_nxt        = probe_r;
    hit_nxt          = hit_r;
    out_valid_nxt    = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_LOAD: begin
              if (table_wr) begin
                if (load_offset_r == OFF_W'(KMER_LEN - 1)) begin
                  load_offset_nxt = '0;
                  entry_count_nxt = entry_count_r + CNT_W'(1);
                end else begin
                  load_offset_nxt = load_offset_r + OFF_W'(1);
                end
              end
            end
            MODE_GENOME: begin
              window_nxt = {window_r[1:KMER_LEN-1], in_symbol};
              if (window_fill_r != FILL_W'(KMER_LEN)) begin
                window_fill_nxt = window_fill_r + FILL_W'(1);
              end
              if (genome_pos_r != '1) begin
                genome_pos_nxt = genome_pos_r + POS_WIDTH'(1);
              end
              if (window_fill_nxt == FILL_W'(KMER_LEN)) begin
                lo_nxt    = '0;
                hi_nxt    = entry_count_r;
                state_nxt = ST_READ;
              end
            end
            MODE_RESTART: begin
              window_fill_nxt  = '0;
              genome_pos_nxt   = '0;
              report_count_nxt = '0;
            end
            MODE_CLEAR: begin
              entry_count_nxt = '0;
              load_offset_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (lo_r >= hi_r) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          probe_nxt = rd_addr_c;
          state_nxt = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (cmp_eq_c) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          if ((search_kind_r == SEARCH_LINEAR) || cmp_lt_c) begin
            lo_nxt = CNT_W'(probe_r) + CNT_W'(1);
          end else begin
            hi_nxt = CNT_W'(probe_r);
          end
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (rep_c && (report_count_r != '1)) begin
            report_count_nxt = report_count_r + RPT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      max_reports_r  <= RPT_W'(10);
      search_kind_r  <= SEARCH_BINARY;
      entry_count_r  <= '0;
      load_offset_r  <= '0;
      window_fill_r  <= '0;
      genome_pos_r   <= '0;
      report_count_r <= '0;
      lo_r           <= '0;
      hi_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      entry_count_r  <= entry_count_nxt;
      load_offset_r  <= load_offset_nxt;
      window_fill_r  <= window_fill_nxt;
      genome_pos_r   <= genome_pos_nxt;
      report_count_r <= report_count_nxt;
      lo_r           <= lo_nxt;
      hi_r           <= hi_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_REPORTS: max_reports_r <= cfg_wdata[RPT_W-1:0];
          CFG_SEARCH_KIND: search_kind_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    window_r <= window_nxt;
    probe_r  <= probe_nxt;
    hit_r    <= hit_nxt;
    if (out_load) begin
      out_found_r    <= hit_r;
      out_reported_r <= rep_c;
      out_start_r    <= START_W'(start_pos_c);
    end
  end

  a_compare_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPARE) |-> ($past(state_r) == ST_READ))
    else $error("compare without a preceding table read");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPARE) |-> ((CNT_W'(probe_r) >= lo_r) && (CNT_W'(probe_r) < hi_r)))
    else $error("probe outside search bounds");

  a_bound_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (hi_r <= entry_count_r))
    else $error("search bound beyond loaded entries");

  a_reported_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_reported_r || out_found_r))
    else $error("reported word without a match");

  a_window_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    window_fill_r <= FILL_W'(KMER_LEN))
    else $error("window fill overflow");

endmodule

`default_nettype wire
